// ----- hw/rtl/hpc_pkg.sv -----
// Shared types, constants and byte helpers for the HTTP path canonicalizer.
package hpc_pkg;

  // Configuration port geometry and register map
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_MAX_PATH_BYTES = 1'b0;
  localparam logic [15:0] MAX_PATH_BYTES_RST = 16'd2048;
  localparam logic [15:0] BYTE_COUNT_SAT = 16'hFFFF;

  // Results one input beat can cause
  localparam int unsigned MAX_RESULTS = 4;

  // Status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_BAD_START   = 4'd1;
  localparam logic [3:0] ST_TOO_LONG    = 4'd2;
  localparam logic [3:0] ST_FORBIDDEN   = 4'd3;
  localparam logic [3:0] ST_BAD_ESCAPE  = 4'd4;
  localparam logic [3:0] ST_ENC_CONTROL = 4'd5;
  localparam logic [3:0] ST_ENC_SEP     = 4'd6;
  localparam logic [3:0] ST_DOUBLE_SL   = 4'd7;
  localparam logic [3:0] ST_DOT_SEG     = 4'd8;

  // Escape phase
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HEX  = 2'd2;

  // Segment kind
  localparam logic [1:0] SEG_EMPTY  = 2'd0;
  localparam logic [1:0] SEG_DOT    = 2'd1;
  localparam logic [1:0] SEG_DOTDOT = 2'd2;
  localparam logic [1:0] SEG_OTHER  = 2'd3;

  // Characters
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [3:0] NIB_MASK  = 4'h0F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_mark;
    logic [3:0] status;
  } out_t;

  // Results of one input beat, in order
  typedef struct packed {
    logic [2:0]                 cnt;
    out_t [MAX_RESULTS-1:0]     res;
  } grp_t;

  // Scratch state threaded through successive character pushes
  typedef struct packed {
    logic                          slash_held;
    logic                          longer;
    logic [1:0]                    seg;
    logic                          dss;
    logic                          dots;
    logic                          cand;
    logic [2:0]                    qlen;
    logic [MAX_RESULTS-1:0][7:0]   q;
  } work_t;

  function automatic logic nib_ok(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] nib_val(logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    return v[3:0];
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

  function automatic logic plain_ok(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_DOT ||
           c == CH_UNDER || c == CH_TILDE;
  endfunction

  function automatic work_t enq(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (r.qlen < 3'(MAX_RESULTS)) begin
      r.q[r.qlen[1:0]] = c;
      r.qlen = r.qlen + 3'd1;
    end
    return r;
  endfunction

  // One canonical character: hold slashes, track segments
  function automatic work_t push_char(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (r.cand) r.longer = 1'b1;
    r.cand = 1'b1;
    if (c == CH_SLASH) begin
      if (r.slash_held) r.dss = 1'b1;
      if (r.seg == SEG_DOT || r.seg == SEG_DOTDOT) r.dots = 1'b1;
      r.seg = SEG_EMPTY;
      r.slash_held = 1'b1;
    end else begin
      if (r.slash_held) begin
        r = enq(r, CH_SLASH);
        r.slash_held = 1'b0;
      end
      r = enq(r, c);
      if (c == CH_DOT && r.seg == SEG_EMPTY) r.seg = SEG_DOT;
      else if (c == CH_DOT && r.seg == SEG_DOT) r.seg = SEG_DOTDOT;
      else r.seg = SEG_OTHER;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/hpc_cfg.sv -----
// APB register block holding the path length limit.
module hpc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hpc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [hpc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [hpc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [15:0]                        max_bytes
);

  logic [15:0] max_r;
  logic        hit;

  assign pready    = 1'b1;
  assign hit       = paddr[hpc_pkg::APB_ADDR_W-1] == hpc_pkg::REG_MAX_PATH_BYTES;
  assign max_bytes = max_r;
  assign prdata    = hit ? {16'h0000, max_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= hpc_pkg::MAX_PATH_BYTES_RST;
    end else if (psel && penable && pwrite && pready && hit) begin
      max_r <= pwdata[15:0];
    end
  end

endmodule

// ----- hw/rtl/hpc_scan.sv -----
// Per-byte scanner: path state registers and the result group of one beat.
module hpc_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  hpc_pkg::in_t       item,
  input  logic [15:0]        max_bytes,
  output hpc_pkg::grp_t      grp
);

  logic [1:0]  esc_r, esc;
  logic [3:0]  hi_r, hi;
  logic [15:0] bc_r, bc;
  logic        ef_r;
  logic        sh_r, lo_r, dss_r, dots_r;
  logic [1:0]  seg_r;
  logic [3:0]  fe_r, fe;
  logic [7:0]  b, d;
  logic [3:0]  status;
  logic        failing;
  logic [1:0]  tail;
  hpc_pkg::work_t w;

  always_comb begin
    w            = '0;
    w.slash_held = sh_r;
    w.longer     = lo_r;
    w.seg        = seg_r;
    w.dss        = dss_r;
    w.dots       = dots_r;
    w.cand       = !ef_r;
    b            = item.in_byte;
    fe           = fe_r;
    esc          = esc_r;
    hi           = hi_r;
    d            = {hi_r, hpc_pkg::nib_val(b)};
    bc           = (bc_r == hpc_pkg::BYTE_COUNT_SAT) ? bc_r : bc_r + 16'd1;
    status       = hpc_pkg::ST_OK;

    if (ef_r && b != hpc_pkg::CH_SLASH && fe == hpc_pkg::ST_OK) fe = hpc_pkg::ST_BAD_START;

    unique case (esc_r)
      hpc_pkg::ESC_NONE: begin
        if (b < hpc_pkg::CH_SPACE || b == hpc_pkg::CH_DEL || b == hpc_pkg::CH_QUEST ||
            b == hpc_pkg::CH_HASH || b == hpc_pkg::CH_BSLASH) begin
          if (fe == hpc_pkg::ST_OK) fe = hpc_pkg::ST_FORBIDDEN;
        end else if (b == hpc_pkg::CH_PCT) begin
          esc = hpc_pkg::ESC_PCT;
        end else begin
          w = hpc_pkg::push_char(w, b);
        end
      end
      hpc_pkg::ESC_PCT: begin
        if (hpc_pkg::nib_ok(b)) begin
          hi  = hpc_pkg::nib_val(b);
          esc = hpc_pkg::ESC_HEX;
        end else begin
          if (fe == hpc_pkg::ST_OK) fe = hpc_pkg::ST_BAD_ESCAPE;
          esc = hpc_pkg::ESC_NONE;
        end
      end
      default: begin
        esc = hpc_pkg::ESC_NONE;
        if (!hpc_pkg::nib_ok(b)) begin
          if (fe == hpc_pkg::ST_OK) fe = hpc_pkg::ST_BAD_ESCAPE;
        end else if (d < hpc_pkg::CH_SPACE || d == hpc_pkg::CH_DEL) begin
          if (fe == hpc_pkg::ST_OK) fe = hpc_pkg::ST_ENC_CONTROL;
        end else if (d == hpc_pkg::CH_DOT || d == hpc_pkg::CH_SLASH ||
                     d == hpc_pkg::CH_BSLASH) begin
          if (fe == hpc_pkg::ST_OK) fe = hpc_pkg::ST_ENC_SEP;
        end else if (hpc_pkg::plain_ok(d)) begin
          w = hpc_pkg::push_char(w, d);
        end else begin
          // re-encode as percent plus two uppercase hex digits
          w = hpc_pkg::push_char(w, hpc_pkg::CH_PCT);
          w = hpc_pkg::push_char(w, hpc_pkg::hex_digit(d[7:4]));
          w = hpc_pkg::push_char(w, hpc_pkg::hex_digit(d[3:0] & hpc_pkg::NIB_MASK));
        end
      end
    endcase

    if (item.in_last) begin
      if (esc != hpc_pkg::ESC_NONE && fe == hpc_pkg::ST_OK) fe = hpc_pkg::ST_BAD_ESCAPE;
      if (w.seg == hpc_pkg::SEG_DOT || w.seg == hpc_pkg::SEG_DOTDOT) w.dots = 1'b1;
      if (w.slash_held && !w.longer) w = hpc_pkg::enq(w, hpc_pkg::CH_SLASH);
      priority if (fe == hpc_pkg::ST_BAD_START) status = hpc_pkg::ST_BAD_START;
      else if (bc > max_bytes)            status = hpc_pkg::ST_TOO_LONG;
      else if (fe != hpc_pkg::ST_OK)      status = fe;
      else if (w.dss)                     status = hpc_pkg::ST_DOUBLE_SL;
      else if (w.dots)                    status = hpc_pkg::ST_DOT_SEG;
      else                                status = hpc_pkg::ST_OK;
      failing = status != hpc_pkg::ST_OK;
    end else begin
      failing = fe != hpc_pkg::ST_OK || w.dss || w.dots || bc > max_bytes;
    end

    grp = '0;
    if (!failing) begin
      grp.cnt = w.qlen;
      for (int i = 0; i < hpc_pkg::MAX_RESULTS; i++) begin
        if (3'(i) < w.qlen) begin
          grp.res[i].out_byte = w.q[i];
          grp.res[i].has_byte = 1'b1;
        end
      end
    end
    tail = grp.cnt[1:0] - 2'd1;
    if (item.in_last) begin
      if (grp.cnt == 3'd0) begin
        grp.cnt               = 3'd1;
        grp.res[0].end_mark   = 1'b1;
        grp.res[0].status     = status;
      end else begin
        grp.res[tail].end_mark = 1'b1;
        grp.res[tail].status   = status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && item.in_last)) begin
      esc_r  <= hpc_pkg::ESC_NONE;
      hi_r   <= 4'h0;
      bc_r   <= 16'h0000;
      ef_r   <= 1'b1;
      sh_r   <= 1'b0;
      lo_r   <= 1'b0;
      seg_r  <= hpc_pkg::SEG_EMPTY;
      fe_r   <= hpc_pkg::ST_OK;
      dss_r  <= 1'b0;
      dots_r <= 1'b0;
    end else if (adv) begin
      esc_r  <= esc;
      hi_r   <= hi;
      bc_r   <= bc;
      ef_r   <= 1'b0;
      sh_r   <= w.slash_held;
      lo_r   <= w.longer;
      seg_r  <= w.seg;
      fe_r   <= fe;
      dss_r  <= w.dss;
      dots_r <= w.dots;
    end
  end

endmodule

// ----- hw/rtl/hpc_outbuf.sv -----
// Result group register drained one result beat per cycle while out_stall is low.
module hpc_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               grp_valid,
  input  hpc_pkg::grp_t      grp,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output hpc_pkg::out_t      out_data
);

  logic [2:0]                             left_r;
  logic [1:0]                             rd_r;
  hpc_pkg::out_t [hpc_pkg::MAX_RESULTS-1:0] res_r;
  logic                                   pop;
  logic                                   room;

  assign out_valid = left_r != 3'd0;
  assign out_data  = res_r[rd_r];
  assign pop       = out_valid && !out_stall;
  assign room      = !out_valid || (pop && left_r == 3'd1);
  assign take      = grp_valid && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 3'd0;
      rd_r   <= 2'd0;
    end else if (take) begin
      left_r <= grp.cnt;
      rd_r   <= 2'd0;
    end else if (pop) begin
      left_r <= left_r - 3'd1;
      rd_r   <= rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= grp.res;
    end
  end

endmodule

// ----- hw/rtl/http_path_canonicalizer.sv -----
// Top level of the HTTP path canonicalizer: input register, scanner, result buffer, APB.
//
// Feed the raw request path one byte per beat on the in_ channel, with in_last on its
// final byte; canonical bytes come back on the out_ channel, one result per beat, and
// the last result of a path carries end_mark with the path status (0 ok, nonzero means
// discard everything emitted for that path). Control bytes, '?', '#' and backslash are
// rejected, as are escapes of control bytes, '.', '/' and backslash; other escapes are
// decoded to the plain character when unreserved and otherwise re-emitted as '%' with
// two uppercase hex digits; a trailing slash is dropped unless the whole path is "/".
// No path bytes follow the first known error. Timing: an input beat sits in an input
// register, then the scanner turns it into a group of zero to four results, loaded
// into the result buffer. The input side accepts one beat per cycle as long as each
// beat yields at most one result and out_stall is low; a beat yielding k results holds
// the buffer for k output beats, so the single output port sets the throughput (for
// example an escape re-encoded after a held slash yields four results). A beat that
// yields nothing leaves the buffer free. max_path_bytes sits at APB byte address 0
// (reset 2048); write it only while no path is in flight.
module http_path_canonicalizer (
  input  logic                               clk,
  input  logic                               rst_n,
  // input byte stream
  input  logic                               in_valid,
  output logic                               in_stall,
  input  hpc_pkg::in_t                       in_data,
  // result stream
  output logic                               out_valid,
  input  logic                               out_stall,
  output hpc_pkg::out_t                      out_data,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hpc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [hpc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [hpc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  logic          in_v_r;
  hpc_pkg::in_t  in_pl_r;
  logic          take;
  logic [15:0]   max_bytes;
  hpc_pkg::grp_t grp;

  // Hold the input beat while the result buffer is still busy with the previous group
  assign in_stall = in_v_r && !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  // Capture payload only on an accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_pl_r <= in_data;
    end
  end

  hpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_bytes (max_bytes)
  );

  // Advance path state exactly when the beat's results enter the buffer
  hpc_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (take),
    .item      (in_pl_r),
    .max_bytes (max_bytes),
    .grp       (grp)
  );

  hpc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (in_v_r),
    .grp       (grp),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
